FILE: hdl/isopav_pkg.sv
// ----------------------------------------------------------------------------
// isopav_pkg: shared types and constants of the isotonic regression unit
// Transaction payloads, register map, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package isopav_pkg;

   localparam int VALUE_W       = 32;   // Q16.16 sample and fitted values
   localparam int WEIGHT_IN_W   = 16;   // weight of one observation
   localparam int QUOT_W        = 32;   // quotient width of the pooling divide
   localparam int DEF_MAX_ITEMS = 64;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_UNIT_WEIGHTS = 1'b0;   // register index, paddr[2]

   typedef struct packed {
      logic signed [VALUE_W-1:0]   sample_value;
      logic        [WEIGHT_IN_W-1:0] sample_weight;
      logic                        final_item;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] fitted_value;
      logic                      run_end;
      logic                      overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MRG_CHK,
      ST_MRG_CMP,
      ST_MRG_MUL,
      ST_MRG_START,
      ST_MRG_DIV,
      ST_OUT_LOAD,
      ST_OUT_MEAN,
      ST_OUT_BOUND,
      ST_OUT_EMIT
   } state_type;

endpackage

FILE: hdl/isopav_div.sv
// ----------------------------------------------------------------------------
// isopav_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. The caller guarantees that
// the quotient fits QUOT_W bits, so the partial remainder starts from the
// upper dividend bits and only QUOT_W steps are needed.
// ----------------------------------------------------------------------------
module isopav_div #(
   parameter int WW = 22
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            div_start,
   input  logic [WW+isopav_pkg::QUOT_W-1:0] dividend,
   input  logic [WW-1:0]                   divisor,
   output logic                            div_done,
   output logic [isopav_pkg::QUOT_W-1:0]   quotient
);
   import isopav_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [WW-1:0]     rem_ff, rem_in;
   logic [QUOT_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [WW+1:0]     trial;
   logic              borrow;

   always_comb begin
      trial  = {1'b0, rem_ff, quo_ff[QUOT_W-1]} - {2'b00, divisor};
      borrow = trial[WW+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_start) begin
         rem_in = dividend[WW+QUOT_W-1:QUOT_W];
         quo_in = dividend[QUOT_W-1:0];
         cnt_in = CNT_W'(QUOT_W);
      end else if (cnt_ff != '0) begin
         // The shifted-in dividend bits are replaced by quotient bits.
         rem_in  = borrow ? {rem_ff[WW-2:0], quo_ff[QUOT_W-1]} : trial[WW-1:0];
         quo_in  = {quo_ff[QUOT_W-2:0], ~borrow};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/isotonic_regression_pav_unit.sv
// ----------------------------------------------------------------------------
// isotonic_regression_pav_unit: weighted isotonic regression, pool adjacent
// violators
// Each observation is pushed on a block stack and pooled with the blocks
// below while their means violate monotone order; the final observation
// releases one fitted value per stored observation, in index order.
// ----------------------------------------------------------------------------
// An observation ends when no block lies below the new one or when the
// comparison with the block below pools nothing; each pooling step runs the
// multiply state and then the divider, which the sequencer starts once per
// merge, and then compares again.
// The request side is stalled for the whole time a transaction is worked on.
// After the final observation, the mean of each stack block and the start
// of the block above it are read out, the top block coming from registers,
// and then one fitted value per cycle goes out while the result side takes them.
// Observations beyond MAX_ITEMS are dropped and flag overflow on the results.
// ----------------------------------------------------------------------------
module isotonic_regression_pav_unit #(
   parameter int MAX_ITEMS = isopav_pkg::DEF_MAX_ITEMS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  isopav_pkg::req_type            req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output isopav_pkg::rsp_type            rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [isopav_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [isopav_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [isopav_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                           csr_pready
);
   import isopav_pkg::*;

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int WW = WEIGHT_IN_W + AW;
   localparam int PW = WW + QUOT_W;

   // Block stack below the top block; the top block lives in registers.
   logic [AW-1:0]             mem_start  [MAX_ITEMS];
   logic [WW-1:0]             mem_weight [MAX_ITEMS];
   logic [VALUE_W-1:0]        mem_mean   [MAX_ITEMS];

   state_type                 state_ff, state_in;
   logic [AW-1:0]             sp_ff, sp_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic                      final_ff, final_in;
   logic                      unit_w_ff, unit_w_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic [AW-1:0]             top_start_ff, top_start_in;
   logic [WW-1:0]             top_weight_ff, top_weight_in;
   logic signed [VALUE_W-1:0] top_mean_ff, top_mean_in;

   logic [AW-1:0]             rd_start_ff;
   logic [WW-1:0]             rd_weight_ff;
   logic signed [VALUE_W-1:0] rd_mean_ff;

   logic [QUOT_W-1:0]         mag_ff, mag_in;
   logic [WW-1:0]             wsum_ff, wsum_in;
   logic [PW-1:0]             prod_ff, prod_in;

   logic [AW-1:0]             blk_ff, blk_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             bound_ff, bound_in;
   logic signed [VALUE_W-1:0] cur_mean_ff, cur_mean_in;

   logic                      mem_we;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic                      div_start;
   logic                      div_done;
   logic [QUOT_W-1:0]         quotient;

   logic                      req_take;
   logic                      slot_free;
   logic                      csr_write;
   logic [WW-1:0]             new_weight;
   logic [VALUE_W:0]          mean_diff;
   logic [VALUE_W:0]          pooled_mean;
   logic [CW-1:0]             idx_next;
   logic [AW:0]               blk_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign unit_w_in  = (csr_write && (csr_paddr[2] == REG_UNIT_WEIGHTS)) ?
                       csr_pwdata[0] : unit_w_ff;
   assign csr_prdata = (csr_paddr[2] == REG_UNIT_WEIGHTS) ?
                       {{(CSR_DW-1){1'b0}}, unit_w_ff} : '0;

   // A zero weight counts as one, so the pooled weight is never zero.
   assign new_weight = (unit_w_ff || (req_data.sample_weight == '0)) ?
                       WW'(1) : WW'(req_data.sample_weight);

   assign mean_diff   = {rd_mean_ff[VALUE_W-1], rd_mean_ff} -
                        {top_mean_ff[VALUE_W-1], top_mean_ff};
   assign pooled_mean = {rd_mean_ff[VALUE_W-1], rd_mean_ff} - {1'b0, quotient};
   assign idx_next    = idx_ff + 1'b1;
   assign blk_next    = {1'b0, blk_ff} + 1'b1;

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      final_in      = final_ff;
      top_start_in  = top_start_ff;
      top_weight_in = top_weight_ff;
      top_mean_in   = top_mean_ff;
      mag_in        = mag_ff;
      wsum_in       = wsum_ff;
      prod_in       = prod_ff;
      blk_in        = blk_ff;
      idx_in        = idx_ff;
      bound_in      = bound_ff;
      cur_mean_in   = cur_mean_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = sp_ff - 1'b1;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               final_in = req_data.final_item;
               blk_in   = '0;
               idx_in   = '0;
               if (count_ff < CW'(MAX_ITEMS)) begin
                  // The old top block goes down into the stack.
                  if (count_ff != '0) begin
                     mem_we = 1'b1;
                     sp_in  = sp_ff + 1'b1;
                  end
                  top_start_in  = count_ff[AW-1:0];
                  top_weight_in = new_weight;
                  top_mean_in   = req_data.sample_value;
                  count_in      = count_ff + 1'b1;
                  state_in      = ST_MRG_CHK;
               end else begin
                  dropped_in = 1'b1;
                  state_in   = req_data.final_item ? ST_OUT_LOAD : ST_IDLE;
               end
            end
         end

         ST_MRG_CHK: begin
            if (sp_ff != '0) begin
               rd_en    = 1'b1;
               state_in = ST_MRG_CMP;
            end else begin
               state_in = final_ff ? ST_OUT_LOAD : ST_IDLE;
            end
         end

         ST_MRG_CMP: begin
            if (rd_mean_ff >= top_mean_ff) begin
               mag_in   = mean_diff[QUOT_W-1:0];
               wsum_in  = rd_weight_ff + top_weight_ff;
               state_in = ST_MRG_MUL;
            end else begin
               state_in = final_ff ? ST_OUT_LOAD : ST_IDLE;
            end
         end

         ST_MRG_MUL: begin
            prod_in  = top_weight_ff * mag_ff;
            state_in = ST_MRG_START;
         end

         ST_MRG_START: begin
            div_start = 1'b1;
            state_in  = ST_MRG_DIV;
         end

         ST_MRG_DIV: begin
            if (div_done) begin
               // The block below absorbs the top block and becomes the top.
               top_mean_in   = pooled_mean[VALUE_W-1:0];
               top_weight_in = wsum_ff;
               top_start_in  = rd_start_ff;
               sp_in         = sp_ff - 1'b1;
               state_in      = ST_MRG_CHK;
            end
         end

         ST_OUT_LOAD: begin
            if (blk_ff == sp_ff) begin
               cur_mean_in = top_mean_ff;
               bound_in    = count_ff;
               state_in    = ST_OUT_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = blk_ff;
               state_in = ST_OUT_MEAN;
            end
         end

         ST_OUT_MEAN: begin
            cur_mean_in = rd_mean_ff;
            if (blk_next == {1'b0, sp_ff}) begin
               bound_in = CW'(top_start_ff);
               state_in = ST_OUT_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = blk_next[AW-1:0];
               state_in = ST_OUT_BOUND;
            end
         end

         ST_OUT_BOUND: begin
            bound_in = CW'(rd_start_ff);
            state_in = ST_OUT_EMIT;
         end

         ST_OUT_EMIT: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.fitted_value = cur_mean_ff;
               rsp_data_in.run_end      = (idx_next == count_ff);
               rsp_data_in.overflow     = dropped_ff;
               idx_in                   = idx_next;
               if (idx_next == count_ff) begin
                  sp_in      = '0;
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else if (idx_next == bound_ff) begin
                  blk_in   = blk_next[AW-1:0];
                  state_in = ST_OUT_LOAD;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         final_ff     <= 1'b0;
         unit_w_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         blk_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         final_ff     <= final_in;
         unit_w_ff    <= unit_w_in;
         rsp_valid_ff <= rsp_valid_in;
         blk_ff       <= blk_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      top_start_ff  <= top_start_in;
      top_weight_ff <= top_weight_in;
      top_mean_ff   <= top_mean_in;
      mag_ff        <= mag_in;
      wsum_ff       <= wsum_in;
      prod_ff       <= prod_in;
      bound_ff      <= bound_in;
      cur_mean_ff   <= cur_mean_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Block stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_start[sp_ff]  <= top_start_ff;
         mem_weight[sp_ff] <= top_weight_ff;
         mem_mean[sp_ff]   <= top_mean_ff;
      end
      if (rd_en) begin
         rd_start_ff  <= mem_start[rd_addr];
         rd_weight_ff <= mem_weight[rd_addr];
         rd_mean_ff   <= mem_mean[rd_addr];
      end
   end

   isopav_div #(
      .WW (WW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (prod_ff),
      .divisor   (wsum_ff),
      .div_done  (div_done),
      .quotient  (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
